// File: rtl/core/hid_mouse_report_accumulator_core_macros.svh
// Assertion macros for the checker file of the mouse report accumulator.
`ifndef HID_MOUSE_REPORT_ACCUMULATOR_CORE_MACROS_SVH
`define HID_MOUSE_REPORT_ACCUMULATOR_CORE_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define HMRA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked while reset is held.
`define HMRA_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/hmra_pkg.sv
`default_nettype none

package hmra_pkg;

  typedef enum logic [2:0] {
    OP_REL_MOVE    = 3'd0,
    OP_ABS_MOVE    = 3'd1,
    OP_BUTTONS     = 3'd2,
    OP_WHEEL       = 3'd3,
    OP_CONSUME     = 3'd4,
    OP_RELEASE_BTN = 3'd5,
    OP_SET_MODE    = 3'd6
  } op_t;

  localparam logic [15:0] ABS_LIMIT          = 16'd32767;
  localparam logic [7:0]  BUTTON_REJECT_MASK = 8'hE0;

  // Mouse state, which is also the snapshot carried by every result.
  typedef struct packed {
    logic        [4:0]  buttons;
    logic signed [15:0] acc_dx;
    logic signed [15:0] acc_dy;
    logic signed [31:0] vpos_x;
    logic signed [31:0] vpos_y;
    logic        [14:0] apos_x;
    logic        [14:0] apos_y;
    logic signed [7:0]  acc_wv;
    logic signed [7:0]  acc_wh;
    logic signed [7:0]  rec_wv;
    logic signed [7:0]  rec_wh;
  } snap_t;

  function automatic logic signed [7:0] sat_add8(logic signed [7:0] a, logic signed [7:0] b);
    logic signed [8:0] s;
    s = {a[7], a} + {b[7], b};
    if (s[8] != s[7]) begin
      return s[8] ? 8'sh80 : 8'sh7F;
    end
    return s[7:0];
  endfunction

  function automatic logic signed [15:0] sat_add16(logic signed [15:0] a,
                                                   logic signed [15:0] b);
    logic signed [16:0] s;
    s = {a[15], a} + {b[15], b};
    if (s[16] != s[15]) begin
      return s[16] ? 16'sh8000 : 16'sh7FFF;
    end
    return s[15:0];
  endfunction

  function automatic logic signed [31:0] sat_add32(logic signed [31:0] a,
                                                   logic signed [15:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {{17{b[15]}}, b};
    if (s[32] != s[31]) begin
      return s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    return s[31:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/hid_mouse_report_accumulator_core.sv
// A command transferred in is held in the input stage and then moves into the
// state register, which doubles as the result register. Throughput: one command
// per cycle unless the result side stalls, set by the single update of the state
// register. Reset: synchronous, active low; it empties both stages and sets the
// whole mouse state to zero (relative mode, no buttons, nothing pending).
`default_nettype none

module hid_mouse_report_accumulator_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // Command channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic        [2:0]  in_opcode,
  input  wire logic signed [15:0] in_delta_x,
  input  wire logic signed [15:0] in_delta_y,
  input  wire logic        [15:0] in_target_x,
  input  wire logic        [15:0] in_target_y,
  input  wire logic        [7:0]  in_button_map,
  input  wire logic signed [7:0]  in_wheel_vert,
  input  wire logic signed [7:0]  in_wheel_horiz,
  input  wire logic               in_mode_sel,
  // Result channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_accepted,
  output logic             [4:0]  out_button_state,
  output logic signed      [15:0] out_pending_dx,
  output logic signed      [15:0] out_pending_dy,
  output logic signed      [31:0] out_virt_pos_x,
  output logic signed      [31:0] out_virt_pos_y,
  output logic             [14:0] out_absolute_x,
  output logic             [14:0] out_absolute_y,
  output logic signed      [7:0]  out_pending_wheel_vert,
  output logic signed      [7:0]  out_pending_wheel_horiz,
  output logic signed      [7:0]  out_last_wheel_vert,
  output logic signed      [7:0]  out_last_wheel_horiz
);
  import hmra_pkg::*;

  // The block has two register stages. The first holds the command that has
  // just been transferred in. The second is the mouse state itself together
  // with the accepted flag: the state only changes when a command moves out of
  // the first stage, so the state register always holds the snapshot that
  // belongs to the result on offer and doubles as the result register.
  //
  // The selected mode has no effect on any result beyond the clears that a
  // mode change causes, so the mode value itself is not kept.

  // Input stage
  logic               s1_valid_r;
  logic        [2:0]  s1_opcode_r;
  logic signed [15:0] s1_delta_x_r;
  logic signed [15:0] s1_delta_y_r;
  logic        [15:0] s1_target_x_r;
  logic        [15:0] s1_target_y_r;
  logic        [7:0]  s1_button_map_r;
  logic signed [7:0]  s1_wheel_vert_r;
  logic signed [7:0]  s1_wheel_horiz_r;
  logic               s1_mode_sel_r;

  // State and result stage
  snap_t st_r;
  snap_t st_nxt;
  logic  out_valid_r;
  logic  accepted_r;
  logic  accepted_nxt;

  logic  out_free;
  logic  s1_load;
  logic  s1_fire;

  // The result register can take a new result when it is empty or when its
  // present result is transferred out at this edge. The input stage moves on
  // under the same condition, so a new command is taken every cycle unless the
  // result side holds both stages full.
  assign out_free = !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign s1_load  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_load) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_opcode_r      <= in_opcode;
      s1_delta_x_r     <= in_delta_x;
      s1_delta_y_r     <= in_delta_y;
      s1_target_x_r    <= in_target_x;
      s1_target_y_r    <= in_target_y;
      s1_button_map_r  <= in_button_map;
      s1_wheel_vert_r  <= in_wheel_vert;
      s1_wheel_horiz_r <= in_wheel_horiz;
      s1_mode_sel_r    <= in_mode_sel;
    end
  end

  // Command decode and state update. A rejected command, including the unused
  // opcode, leaves every state field as it was and only clears the flag.
  always_comb begin
    st_nxt       = st_r;
    accepted_nxt = 1'b1;
    unique case (op_t'(s1_opcode_r))
      OP_REL_MOVE: begin
        // Relative moves saturate separately in the pending deltas and in the
        // wider virtual position.
        st_nxt.acc_dx = sat_add16(st_r.acc_dx, s1_delta_x_r);
        st_nxt.acc_dy = sat_add16(st_r.acc_dy, s1_delta_y_r);
        st_nxt.vpos_x = sat_add32(st_r.vpos_x, s1_delta_x_r);
        st_nxt.vpos_y = sat_add32(st_r.vpos_y, s1_delta_y_r);
      end
      OP_ABS_MOVE: begin
        // Both coordinates must lie within the 15-bit range, or neither is taken.
        if ((s1_target_x_r > ABS_LIMIT) || (s1_target_y_r > ABS_LIMIT)) begin
          accepted_nxt = 1'b0;
        end else begin
          st_nxt.apos_x = s1_target_x_r[14:0];
          st_nxt.apos_y = s1_target_y_r[14:0];
        end
      end
      OP_BUTTONS: begin
        if ((s1_button_map_r & BUTTON_REJECT_MASK) != 8'd0) begin
          accepted_nxt = 1'b0;
        end else begin
          st_nxt.buttons = s1_button_map_r[4:0];
        end
      end
      OP_WHEEL: begin
        st_nxt.rec_wv = s1_wheel_vert_r;
        st_nxt.rec_wh = s1_wheel_horiz_r;
        st_nxt.acc_wv = sat_add8(st_r.acc_wv, s1_wheel_vert_r);
        st_nxt.acc_wh = sat_add8(st_r.acc_wh, s1_wheel_horiz_r);
      end
      OP_CONSUME: begin
        st_nxt.acc_dx = '0;
        st_nxt.acc_dy = '0;
        st_nxt.acc_wv = '0;
        st_nxt.acc_wh = '0;
      end
      OP_RELEASE_BTN: begin
        st_nxt.buttons = '0;
      end
      OP_SET_MODE: begin
        // A mode change drops buttons and everything pending; going back to
        // relative mode also restarts the virtual position from the origin.
        st_nxt.buttons = '0;
        st_nxt.acc_dx  = '0;
        st_nxt.acc_dy  = '0;
        st_nxt.acc_wv  = '0;
        st_nxt.acc_wh  = '0;
        if (!s1_mode_sel_r) begin
          st_nxt.vpos_x = '0;
          st_nxt.vpos_y = '0;
        end
      end
      default: begin
        accepted_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_fire) begin
        st_r        <= st_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      accepted_r <= accepted_nxt;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_accepted            = accepted_r;
  assign out_button_state        = st_r.buttons;
  assign out_pending_dx          = st_r.acc_dx;
  assign out_pending_dy          = st_r.acc_dy;
  assign out_virt_pos_x          = st_r.vpos_x;
  assign out_virt_pos_y          = st_r.vpos_y;
  assign out_absolute_x          = st_r.apos_x;
  assign out_absolute_y          = st_r.apos_y;
  assign out_pending_wheel_vert  = st_r.acc_wv;
  assign out_pending_wheel_horiz = st_r.acc_wh;
  assign out_last_wheel_vert     = st_r.rec_wv;
  assign out_last_wheel_horiz    = st_r.rec_wh;

endmodule

`default_nettype wire

// File: rtl/core/hmra_checker.sv
`default_nettype none

`include "hid_mouse_report_accumulator_core_macros.svh"

module hmra_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic               out_accepted,
  input wire logic        [4:0]  out_button_state,
  input wire logic signed [15:0] out_pending_dx,
  input wire logic signed [15:0] out_pending_dy,
  input wire logic signed [31:0] out_virt_pos_x,
  input wire logic signed [31:0] out_virt_pos_y,
  input wire logic        [14:0] out_absolute_x,
  input wire logic        [14:0] out_absolute_y,
  input wire logic signed [7:0]  out_pending_wheel_vert,
  input wire logic signed [7:0]  out_pending_wheel_horiz,
  input wire logic signed [7:0]  out_last_wheel_vert,
  input wire logic signed [7:0]  out_last_wheel_horiz
);
  import hmra_pkg::*;

  snap_t cur;
  snap_t prev_r;
  logic  same_as_prev;

  always_comb begin
    cur.buttons = out_button_state;
    cur.acc_dx  = out_pending_dx;
    cur.acc_dy  = out_pending_dy;
    cur.vpos_x  = out_virt_pos_x;
    cur.vpos_y  = out_virt_pos_y;
    cur.apos_x  = out_absolute_x;
    cur.apos_y  = out_absolute_y;
    cur.acc_wv  = out_pending_wheel_vert;
    cur.acc_wh  = out_pending_wheel_horiz;
    cur.rec_wv  = out_last_wheel_vert;
    cur.rec_wh  = out_last_wheel_horiz;
  end

  // Snapshot of the last transferred result; the state after reset is all zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
    end else if (out_valid && !out_stall) begin
      prev_r <= cur;
    end
  end

  assign same_as_prev = (cur == prev_r);

  `HMRA_ASSERT_RST(a_reset_empties, !rst_n |=> !out_valid, "result offered just after reset")

  `HMRA_ASSERT(a_stalled_result_holds,
    out_valid && out_stall |=> out_valid && $stable(cur) && $stable(out_accepted),
    "stalled result changed")

  `HMRA_ASSERT(a_reject_keeps_state, out_valid && !out_accepted |-> same_as_prev,
    "rejected command changed the mouse state")

  `HMRA_ASSERT(a_stall_only_when_full, in_stall |-> out_valid && out_stall,
    "command side stalled while result side can move")

endmodule

bind hid_mouse_report_accumulator_core hmra_checker u_hmra_checker (.*);

`default_nettype wire
